[rtl/upfp_pkg.sv]
// ----------------------------------------------------------------------------
// UBX position frame parser package
// Shared constants and types for the frame parser and its word capture lanes.
// ----------------------------------------------------------------------------
package upfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

	localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CKSUM    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_EXP_CLASS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_ID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LON_OFF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAT_OFF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFF = 3'd5;

	localparam logic [BYTE_W-1:0] RST_EXP_CLASS  = 8'd1;
	localparam logic [BYTE_W-1:0] RST_EXP_ID     = 8'd7;
	localparam logic [LEN_W-1:0]  RST_EXP_LENGTH = 16'd92;
	localparam logic [LEN_W-1:0]  RST_LON_OFF    = 16'd24;
	localparam logic [LEN_W-1:0]  RST_LAT_OFF    = 16'd28;
	localparam logic [LEN_W-1:0]  RST_HEIGHT_OFF = 16'd32;

	typedef struct packed {
		logic             clear;
		logic             load;
		logic [LEN_W-1:0] count;
		logic [BYTE_W-1:0] data;
	} cap_ctrl_t;

endpackage

[rtl/upfp_if.sv]
// ----------------------------------------------------------------------------
// UBX position frame parser channels
// Valid/ready interfaces for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface upfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface upfp_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_status;
	logic signed [31:0] longitude;
	logic signed [31:0] latitude;
	logic signed [31:0] height;

	modport source (output valid, output frame_status, output longitude,
		output latitude, output height, input ready);
	modport sink (input valid, input frame_status, input longitude,
		input latitude, input height, output ready);
endinterface

[rtl/upfp_word_capture.sv]
// ----------------------------------------------------------------------------
// UBX word capture lane
// Collects one little-endian 32-bit word at a configured payload offset.
// ----------------------------------------------------------------------------
module upfp_word_capture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  upfp_pkg::cap_ctrl_t           ctrl,
	input  logic [upfp_pkg::LEN_W-1:0]    offset,
	output logic [upfp_pkg::WORD_W-1:0]   word
);
	import upfp_pkg::*;

	logic [LEN_W:0]      diff;
	logic                hit;
	logic [1:0]          lane;
	logic [WORD_W-1:0]   word_q;

	assign diff = {1'b0, ctrl.count} - {1'b0, offset};
	assign hit  = (diff[LEN_W:2] == '0);
	assign lane = diff[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctrl.clear) begin
			word_q <= '0;
		end else if (ctrl.load && hit) begin
			case (lane)
				2'd0: word_q[7:0]   <= ctrl.data;
				2'd1: word_q[15:8]  <= ctrl.data;
				2'd2: word_q[23:16] <= ctrl.data;
				2'd3: word_q[31:24] <= ctrl.data;
				default: word_q <= word_q;
			endcase
		end
	end

	assign word = word_q;

endmodule

[rtl/ubx_position_frame_parser.sv]
// ----------------------------------------------------------------------------
// UBX position frame parser
// Parses a UBX byte stream and reports position words with a frame status.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. A byte is registered on entry and is
// parsed from that register, so the block sustains one byte per clock;
// the only stall comes from the result register, which holds a finished
// frame result until the sink takes it, and only the last checksum byte
// of a frame waits on it. The frame result is registered when that byte is
// parsed. Configuration writes take effect
// on the next cycle.
// ----------------------------------------------------------------------------
module ubx_position_frame_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	upfp_rx_if.sink                           rx,
	upfp_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [upfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [upfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import upfp_pkg::*;

	typedef enum logic [3:0] {
		PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LENLO,
		PH_LENHI, PH_PAYLOAD, PH_CKA, PH_CKB
	} phase_t;

	logic [BYTE_W-1:0]  exp_class_q;
	logic [BYTE_W-1:0]  exp_id_q;
	logic [LEN_W-1:0]   exp_length_q;
	logic [LEN_W-1:0]   lon_off_q;
	logic [LEN_W-1:0]   lat_off_q;
	logic [LEN_W-1:0]   height_off_q;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;

	phase_t             phase_q;
	logic [LEN_W-1:0]   count_q;
	logic [BYTE_W-1:0]  sum_a_q;
	logic [BYTE_W-1:0]  sum_b_q;
	logic [BYTE_W-1:0]  class_q;
	logic [BYTE_W-1:0]  id_q;
	logic [LEN_W-1:0]   length_q;
	logic [BYTE_W-1:0]  ck_a_q;

	logic               res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]  lon_q;
	logic [WORD_W-1:0]  lat_q;
	logic [WORD_W-1:0]  height_q;

	logic               out_free;
	logic               adv;
	logic               emit;
	logic [BYTE_W-1:0]  sum_a_base;
	logic [BYTE_W-1:0]  sum_b_base;
	logic [BYTE_W-1:0]  sum_a_next;
	logic [BYTE_W-1:0]  sum_b_next;
	logic [LEN_W-1:0]   len_full;
	logic [LEN_W:0]     count_inc;
	logic [STATUS_W-1:0] status_next;
	cap_ctrl_t          cap_ctrl;
	logic [WORD_W-1:0]  lon_word;
	logic [WORD_W-1:0]  lat_word;
	logic [WORD_W-1:0]  height_word;

	assign out_free = !res_valid_q || res.ready;
	assign adv      = valid_s1 && ((phase_q != PH_CKB) || out_free);
	assign emit     = adv && (phase_q == PH_CKB);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_class_q  <= RST_EXP_CLASS;
			exp_id_q     <= RST_EXP_ID;
			exp_length_q <= RST_EXP_LENGTH;
			lon_off_q    <= RST_LON_OFF;
			lat_off_q    <= RST_LAT_OFF;
			height_off_q <= RST_HEIGHT_OFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXP_CLASS:  exp_class_q  <= cfg_data[BYTE_W-1:0];
				CFG_EXP_ID:     exp_id_q     <= cfg_data[BYTE_W-1:0];
				CFG_EXP_LENGTH: exp_length_q <= cfg_data;
				CFG_LON_OFF:    lon_off_q    <= cfg_data;
				CFG_LAT_OFF:    lat_off_q    <= cfg_data;
				CFG_HEIGHT_OFF: height_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign sum_a_base = (phase_q == PH_CLASS) ? '0 : sum_a_q;
	assign sum_b_base = (phase_q == PH_CLASS) ? '0 : sum_b_q;
	assign sum_a_next = sum_a_base + byte_s1;
	assign sum_b_next = sum_b_base + sum_a_next;
	assign len_full   = {byte_s1, length_q[BYTE_W-1:0]};
	assign count_inc  = {1'b0, count_q} + {{LEN_W{1'b0}}, 1'b1};

	always_comb begin
		if (ck_a_q != sum_a_q || byte_s1 != sum_b_q) begin
			status_next = STATUS_CKSUM;
		end else if (class_q != exp_class_q || id_q != exp_id_q ||
				length_q != exp_length_q) begin
			status_next = STATUS_MISMATCH;
		end else begin
			status_next = STATUS_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			count_q  <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			class_q  <= '0;
			id_q     <= '0;
			length_q <= '0;
			ck_a_q   <= '0;
		end else if (adv) begin
			case (phase_q)
				PH_SYNC1: begin
					if (byte_s1 == SYNC_FIRST) phase_q <= PH_SYNC2;
				end
				PH_SYNC2: begin
					if (byte_s1 == SYNC_SECOND) phase_q <= PH_CLASS;
					else if (byte_s1 != SYNC_FIRST) phase_q <= PH_SYNC1;
				end
				PH_CLASS: begin
					class_q <= byte_s1;
					count_q <= '0;
					sum_a_q <= sum_a_next;
					sum_b_q <= sum_b_next;
					phase_q <= PH_ID;
				end
				PH_ID: begin
					id_q    <= byte_s1;
					sum_a_q <= sum_a_next;
					sum_b_q <= sum_b_next;
					phase_q <= PH_LENLO;
				end
				PH_LENLO: begin
					length_q <= {{(LEN_W-BYTE_W){1'b0}}, byte_s1};
					sum_a_q  <= sum_a_next;
					sum_b_q  <= sum_b_next;
					phase_q  <= PH_LENHI;
				end
				PH_LENHI: begin
					length_q <= len_full;
					sum_a_q  <= sum_a_next;
					sum_b_q  <= sum_b_next;
					count_q  <= '0;
					phase_q  <= (len_full == '0) ? PH_CKA : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					sum_a_q <= sum_a_next;
					sum_b_q <= sum_b_next;
					count_q <= count_inc[LEN_W-1:0];
					if (count_inc >= {1'b0, length_q}) phase_q <= PH_CKA;
				end
				PH_CKA: begin
					ck_a_q  <= byte_s1;
					phase_q <= PH_CKB;
				end
				PH_CKB: begin
					phase_q <= PH_SYNC1;
				end
				default: begin
					phase_q <= PH_SYNC1;
				end
			endcase
		end
	end

	always_comb begin
		cap_ctrl.clear = adv && (phase_q == PH_CLASS);
		cap_ctrl.load  = adv && (phase_q == PH_PAYLOAD);
		cap_ctrl.count = count_q;
		cap_ctrl.data  = byte_s1;
	end

	upfp_word_capture u_lon (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cap_ctrl),
		.offset (lon_off_q),
		.word   (lon_word)
	);

	upfp_word_capture u_lat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cap_ctrl),
		.offset (lat_off_q),
		.word   (lat_word)
	);

	upfp_word_capture u_height (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cap_ctrl),
		.offset (height_off_q),
		.word   (height_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_next;
			lon_q    <= lon_word;
			lat_q    <= lat_word;
			height_q <= height_word;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.frame_status = status_q;
	assign res.longitude    = $signed(lon_q);
	assign res.latitude     = $signed(lat_q);
	assign res.height       = $signed(height_q);

endmodule

[tb/sv/ubx_position_frame_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UBX position frame parser testbench
// Drives byte streams of whole, broken and noisy frames into the parser under
// several register settings, with random gaps on both channels and one long
// hold-off on the result side. A model of the parser running in the bench
// predicts each frame result, and every result word is checked against it.
// ----------------------------------------------------------------------------
module ubx_position_frame_parser_test;
	import upfp_pkg::*;

	typedef enum logic [3:0] {
		SEEK_SYNC1, SEEK_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
		GET_PAYLOAD, GET_CK_A, GET_CK_B
	} parse_step_t;

	typedef enum {CK_INTACT, CK_A_BAD, CK_B_BAD} ck_fault_t;

	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic signed [WORD_W-1:0] lon;
		logic signed [WORD_W-1:0] lat;
		logic signed [WORD_W-1:0] hgt;
	} position_fix_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam int DRAIN_LIMIT = 5000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	upfp_rx_if  rx_ch ();
	upfp_res_if res_ch ();

	ubx_position_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [BYTE_W-1:0] want_class = RST_EXP_CLASS;
	logic [BYTE_W-1:0] want_id    = RST_EXP_ID;
	logic [LEN_W-1:0]  want_len   = RST_EXP_LENGTH;
	logic [LEN_W-1:0]  lon_ofs    = RST_LON_OFF;
	logic [LEN_W-1:0]  lat_ofs    = RST_LAT_OFF;
	logic [LEN_W-1:0]  hgt_ofs    = RST_HEIGHT_OFF;

	parse_step_t       step      = SEEK_SYNC1;
	logic [LEN_W-1:0]  byte_pos  = '0;
	logic [BYTE_W-1:0] run_a     = '0;
	logic [BYTE_W-1:0] run_b     = '0;
	logic [BYTE_W-1:0] hdr_class = '0;
	logic [BYTE_W-1:0] hdr_id    = '0;
	logic [LEN_W-1:0]  hdr_len   = '0;
	logic [WORD_W-1:0] lon_cap   = '0;
	logic [WORD_W-1:0] lat_cap   = '0;
	logic [WORD_W-1:0] hgt_cap   = '0;
	logic [BYTE_W-1:0] ck_a_rcvd = '0;

	position_fix_t position_fixes_due[$];
	position_fix_t head_fix;
	int            mismatches = 0;
	int            hold_off_cycles = 0;
	bit            rx_gaps_on = 1'b1;
	bit            res_stalls_on = 1'b1;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	function automatic void add_to_sums(input logic [BYTE_W-1:0] b);
		run_a = run_a + b;
		run_b = run_b + run_a;
	endfunction

	function automatic logic [WORD_W-1:0] merge_byte(input logic [WORD_W-1:0] word,
		input logic [LEN_W-1:0] ofs, input logic [LEN_W-1:0] pos,
		input logic [BYTE_W-1:0] b);
		logic [LEN_W:0] rel;
		rel = {1'b0, pos} - {1'b0, ofs};
		if (pos >= ofs && rel < 4) begin
			word[rel[1:0]*8 +: 8] = b;
		end
		return word;
	endfunction

	function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
		position_fix_t fix;
		case (step)
			SEEK_SYNC1: begin
				if (b == SYNC_FIRST) step = SEEK_SYNC2;
			end
			SEEK_SYNC2: begin
				if (b == SYNC_SECOND) step = GET_CLASS;
				else if (b != SYNC_FIRST) step = SEEK_SYNC1;
			end
			GET_CLASS: begin
				run_a = '0;
				run_b = '0;
				lon_cap = '0;
				lat_cap = '0;
				hgt_cap = '0;
				byte_pos = '0;
				hdr_class = b;
				add_to_sums(b);
				step = GET_ID;
			end
			GET_ID: begin
				hdr_id = b;
				add_to_sums(b);
				step = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				hdr_len = {8'h00, b};
				add_to_sums(b);
				step = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				hdr_len = {b, hdr_len[7:0]};
				add_to_sums(b);
				byte_pos = '0;
				step = (hdr_len == 0) ? GET_CK_A : GET_PAYLOAD;
			end
			GET_PAYLOAD: begin
				add_to_sums(b);
				lon_cap = merge_byte(lon_cap, lon_ofs, byte_pos, b);
				lat_cap = merge_byte(lat_cap, lat_ofs, byte_pos, b);
				hgt_cap = merge_byte(hgt_cap, hgt_ofs, byte_pos, b);
				byte_pos = byte_pos + 1'b1;
				if (byte_pos >= hdr_len) step = GET_CK_A;
			end
			GET_CK_A: begin
				ck_a_rcvd = b;
				step = GET_CK_B;
			end
			GET_CK_B: begin
				if (ck_a_rcvd != run_a || b != run_b) begin
					fix.status = STATUS_CKSUM;
				end else if (hdr_class != want_class || hdr_id != want_id ||
					hdr_len != want_len) begin
					fix.status = STATUS_MISMATCH;
				end else begin
					fix.status = STATUS_GOOD;
				end
				fix.lon = lon_cap;
				fix.lat = lat_cap;
				fix.hgt = hgt_cap;
				position_fixes_due.push_back(fix);
				step = SEEK_SYNC1;
			end
			default: step = SEEK_SYNC1;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_EXP_CLASS:  want_class = data[7:0];
			CFG_EXP_ID:     want_id = data[7:0];
			CFG_EXP_LENGTH: want_len = data;
			CFG_LON_OFF:    lon_ofs = data;
			CFG_LAT_OFF:    lat_ofs = data;
			CFG_HEIGHT_OFF: hgt_ofs = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [CFG_DATA_W-1:0] cls,
		input logic [CFG_DATA_W-1:0] id, input logic [CFG_DATA_W-1:0] len,
		input logic [CFG_DATA_W-1:0] lon, input logic [CFG_DATA_W-1:0] lat,
		input logic [CFG_DATA_W-1:0] hgt);
		write_reg(CFG_EXP_CLASS, cls);
		write_reg(CFG_EXP_ID, id);
		write_reg(CFG_EXP_LENGTH, len);
		write_reg(CFG_LON_OFF, lon);
		write_reg(CFG_LAT_OFF, lat);
		write_reg(CFG_HEIGHT_OFF, hgt);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		track_rx_byte(b);
		if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_summed(input logic [BYTE_W-1:0] b, inout logic [BYTE_W-1:0] sa,
		inout logic [BYTE_W-1:0] sb);
		sa = sa + b;
		sb = sb + sa;
		send_byte(b);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
		input logic [LEN_W-1:0] len, input ck_fault_t fault);
		logic [BYTE_W-1:0] sa;
		logic [BYTE_W-1:0] sb;
		sa = '0;
		sb = '0;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_summed(cls, sa, sb);
		send_summed(id, sa, sb);
		send_summed(len[7:0], sa, sb);
		send_summed(len[15:8], sa, sb);
		for (int i = 0; i < len; i++) begin
			send_summed(BYTE_W'($urandom_range(0, 255)), sa, sb);
		end
		if (fault == CK_A_BAD) sa = sa ^ (8'd1 << $urandom_range(0, 7));
		if (fault == CK_B_BAD) sb = sb ^ (8'd1 << $urandom_range(0, 7));
		send_byte(sa);
		send_byte(sb);
	endtask

	task automatic wait_for_fixes(input int limit);
		int waited;
		waited = 0;
		rx_ch.valid <= 1'b0;
		while (position_fixes_due.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		if (position_fixes_due.size() != 0) begin
			note_mismatch("frame results never arrived", position_fixes_due.size(), 0);
			position_fixes_due.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (position_fixes_due.size() == 0) begin
				note_mismatch("unexpected frame result", res_ch.frame_status, 0);
			end else begin
				head_fix = position_fixes_due.pop_front();
				if (res_ch.frame_status !== head_fix.status)
					note_mismatch("frame_status", res_ch.frame_status, head_fix.status);
				if (res_ch.longitude !== head_fix.lon)
					note_mismatch("longitude", res_ch.longitude, head_fix.lon);
				if (res_ch.latitude !== head_fix.lat)
					note_mismatch("latitude", res_ch.latitude, head_fix.lat);
				if (res_ch.height !== head_fix.hgt)
					note_mismatch("height", res_ch.height, head_fix.hgt);
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (res_stalls_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic test_reset_values();
		send_frame(RST_EXP_CLASS, RST_EXP_ID, RST_EXP_LENGTH, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_status_codes();
		write_all_regs(16'd1, 16'd7, 16'd8, 16'd0, 16'd4, 16'd8);
		send_frame(8'd1, 8'd7, 16'd8, CK_INTACT);
		send_frame(8'd2, 8'd7, 16'd8, CK_INTACT);
		send_frame(8'd1, 8'd8, 16'd8, CK_INTACT);
		send_frame(8'd1, 8'd7, 16'd9, CK_INTACT);
		send_frame(8'd1, 8'd7, 16'd8, CK_A_BAD);
		send_frame(8'd1, 8'd7, 16'd8, CK_B_BAD);
		send_frame(8'd0, 8'd7, 16'd8, CK_A_BAD);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_sync_search();
		logic [BYTE_W-1:0] junk [9] = '{8'h00, 8'hFF, SYNC_SECOND, SYNC_FIRST, 8'h00,
			SYNC_SECOND, SYNC_FIRST, SYNC_FIRST, SYNC_FIRST};
		foreach (junk[i]) send_byte(junk[i]);
		send_frame(8'd1, 8'd7, 16'd8, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_zero_length();
		write_all_regs(16'hFF00, 16'h00FF, 16'd0, 16'd0, 16'd4, 16'd8);
		send_frame(8'h00, 8'hFF, 16'd0, CK_INTACT);
		send_frame(8'hFF, 8'h00, 16'd0, CK_INTACT);
		send_frame(8'h00, 8'hFF, 16'd0, CK_B_BAD);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_word_coverage();
		write_all_regs(16'h0000, 16'h00FF, 16'd6, 16'd4, 16'd0, 16'd2);
		send_frame(8'h00, 8'hFF, 16'd6, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
		write_all_regs(16'h0000, 16'h00FF, 16'd6, 16'hFFFF, 16'd5, 16'd6);
		send_frame(8'h00, 8'hFF, 16'd6, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_unknown_index();
		write_reg(CFG_SPARE_6, 16'hFFFF);
		write_reg(CFG_SPARE_7, 16'h0001);
		send_frame(8'h00, 8'hFF, 16'd6, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_longest_frame();
		write_all_regs(16'hFFFF, 16'h0000, 16'd260, 16'd256, 16'd257, 16'd0);
		send_frame(8'hFF, 8'h00, 16'd260, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
	endtask

	task automatic test_result_backpressure();
		write_all_regs(16'hFFFF, 16'h0000, 16'd2, 16'd0, 16'd1, 16'd2);
		rx_gaps_on = 1'b0;
		res_stalls_on = 1'b0;
		hold_off_cycles = 400;
		repeat (12) send_frame(8'hFF, 8'h00, 16'd2, CK_INTACT);
		wait_for_fixes(DRAIN_LIMIT);
		rx_gaps_on = 1'b1;
		res_stalls_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [BYTE_W-1:0] cls;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] nb;
		logic [LEN_W-1:0]  len;
		ck_fault_t         fault;
		int                phase_bytes;
		int                pick;
		for (int ph = 0; ph < 4; ph++) begin
			write_all_regs(CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 65535)),
				CFG_DATA_W'($urandom_range(0, 40)), CFG_DATA_W'($urandom_range(0, 44)),
				CFG_DATA_W'($urandom_range(0, 44)), CFG_DATA_W'($urandom_range(0, 44)));
			phase_bytes = 0;
			while (phase_bytes < 100) begin
				rx_gaps_on = (ph != 3) && ($urandom_range(0, 2) != 0);
				res_stalls_on = (ph != 3) && ($urandom_range(0, 2) != 0);
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					repeat ($urandom_range(1, 6)) begin
						do nb = BYTE_W'($urandom_range(0, 255)); while (nb == SYNC_FIRST);
						send_byte(nb);
					end
					if ($urandom_range(0, 1) == 0) begin
						nb = BYTE_W'($urandom_range(0, 255));
						if (nb == SYNC_FIRST || nb == SYNC_SECOND) nb = 8'h00;
						send_byte(SYNC_FIRST);
						send_byte(nb);
					end
				end else begin
					cls = ($urandom_range(0, 3) != 0) ? want_class :
						BYTE_W'($urandom_range(0, 255));
					id = ($urandom_range(0, 3) != 0) ? want_id :
						BYTE_W'($urandom_range(0, 255));
					len = ($urandom_range(0, 3) != 0) ? want_len :
						LEN_W'($urandom_range(0, 48));
					pick = $urandom_range(0, 9);
					fault = (pick == 0) ? CK_A_BAD : (pick == 1) ? CK_B_BAD : CK_INTACT;
					if ($urandom_range(0, 7) == 0) send_byte(SYNC_FIRST);
					send_frame(cls, id, len, fault);
					phase_bytes += int'(len) + 8;
				end
			end
			wait_for_fixes(DRAIN_LIMIT);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_status_codes();
		test_sync_search();
		test_zero_length();
		test_word_coverage();
		test_unknown_index();
		test_longest_frame();
		test_result_backpressure();
		test_random_traffic();
		wait_for_fixes(DRAIN_LIMIT);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
